>>> hdl/ima_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_pkg
// Shared constants for the integer moving average core: field widths,
// request codes and defaults.
// ----------------------------------------------------------------------------
package ima_pkg;

    // default ring depth and window length after reset
    localparam int DEF_MAX_WINDOW = 256;
    localparam int WINDOW_RESET   = 16;

    // fixed field widths
    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 9;

    // request codes
    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

endpackage

>>> hdl/integer_moving_average_core.sv
`timescale 1ns / 1ps
// Push: the old entry is read from the ring as the request is taken, the sum is
// updated and the sample written, then the one-bit-per-cycle divider forms the
// average. Clear: the window is emptied. One request at a time; the next is
// taken while a result waits at the output.
// Reset (synchronous, active low): window length 16, empty window, no result.
// The ring store itself is not cleared; an old entry is used only once written.
// ----------------------------------------------------------------------------
// integer_moving_average_core
// Sliding-window average of signed 32-bit samples with a ring store in RAM,
// a running sum, a fill count and an iterative divider.
// ----------------------------------------------------------------------------
module integer_moving_average_core #(
    parameter int MAX_WINDOW = ima_pkg::DEF_MAX_WINDOW,
    localparam int CNT_W     = $clog2(MAX_WINDOW + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_req_type,
    input  logic signed [ima_pkg::SAMPLE_W-1:0] i_sample,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [ima_pkg::SAMPLE_W-1:0] o_average,
    output logic [CNT_W-1:0]                    o_fill_level,
    // window length register
    input  logic                                i_cfg_we,
    input  logic [ima_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int SW     = ima_pkg::SAMPLE_W;
    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int SUM_W  = SW + $clog2(MAX_WINDOW);
    localparam int ADD_W  = (SUM_W > SW + 1) ? SUM_W : SW + 1;
    localparam int CMP_W  = (ima_pkg::CFG_W > CNT_W) ? ima_pkg::CFG_W : CNT_W;
    localparam int WIN_RST_I = (ima_pkg::WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW
                             : ((ima_pkg::WINDOW_RESET < 1) ? 1 : ima_pkg::WINDOW_RESET);
    localparam logic [CNT_W-1:0] WIN_RST = CNT_W'(WIN_RST_I);

    // state codes
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]              r_state;
    logic [CNT_W-1:0]        r_win;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_count;
    logic [ADDR_W-1:0]       r_pos;
    logic signed [SW-1:0]    r_smp;
    logic [ADDR_W-1:0]       r_cur;
    logic [SW-1:0]           r_res_avg;
    logic [CNT_W-1:0]        r_res_fill;
    logic                    r_out_valid;
    logic [SW-1:0]           r_average;
    logic [CNT_W-1:0]        r_fill;

    logic                    w_accept;
    logic [CMP_W-1:0]        w_cfg_ext;
    logic [CNT_W-1:0]        w_cfg_win;
    logic [ADDR_W-1:0]       w_rd_pos;
    logic                    w_full;
    logic signed [SW-1:0]    w_old;
    logic signed [SW:0]      w_delta;
    logic signed [ADD_W-1:0] w_sum_wide;
    logic [CNT_W-1:0]        w_next_cnt;
    logic [CNT_W-1:0]        w_pos_inc;
    logic [ADDR_W-1:0]       w_next_pos;
    logic                    w_div_done;
    logic [SUM_W-1:0]        w_div_q;
    logic                    w_out_free;

    // requests held off while busy or during a window length write
    assign o_in_stall = (r_state != S_IDLE) || i_cfg_we;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // window length written: zero acts as one, above depth acts as depth
    assign w_cfg_ext = CMP_W'(i_cfg_data);
    always_comb begin
        if (w_cfg_ext == '0) begin
            w_cfg_win = CNT_W'(1);
        end else if (w_cfg_ext > CMP_W'(MAX_WINDOW)) begin
            w_cfg_win = CNT_W'(MAX_WINDOW);
        end else begin
            w_cfg_win = w_cfg_ext[CNT_W-1:0];
        end
    end

    // slot of the incoming sample
    assign w_rd_pos = (CNT_W'(r_pos) >= r_win) ? '0 : r_pos;

    // sum update once the old entry is back from the ring
    assign w_full     = (r_count >= r_win);
    assign w_delta    = w_full ? ((SW+1)'(r_smp) - (SW+1)'(w_old)) : (SW+1)'(r_smp);
    assign w_sum_wide = ADD_W'(r_sum) + ADD_W'(w_delta);
    assign w_next_cnt = w_full ? r_count : r_count + CNT_W'(1);
    assign w_pos_inc  = CNT_W'(r_cur) + CNT_W'(1);
    assign w_next_pos = (w_pos_inc >= r_win) ? '0 : w_pos_inc[ADDR_W-1:0];

    // ring store
    ima_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_READ),
        .i_waddr (r_cur),
        .i_wdata (r_smp),
        .i_re    (w_accept),
        .i_raddr (w_rd_pos),
        .o_rdata (w_old)
    );

    // sum by count
    ima_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_START),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    // sequencer and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_win   <= WIN_RST;
            r_sum   <= '0;
            r_count <= '0;
            r_pos   <= '0;
        end else if (i_cfg_we) begin
            r_win   <= w_cfg_win;
            r_sum   <= '0;
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_req_type == ima_pkg::REQ_CLEAR) begin
                            r_sum   <= '0;
                            r_count <= '0;
                            r_pos   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_sum   <= w_sum_wide[SUM_W-1:0];
                    r_count <= w_next_cnt;
                    r_pos   <= w_next_pos;
                    r_state <= S_START;
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // request capture and staged result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_smp      <= i_sample;
            r_cur      <= w_rd_pos;
            r_res_avg  <= '0;
            r_res_fill <= '0;
        end
        if (r_state == S_READ) begin
            r_res_fill <= w_next_cnt;
        end
        if ((r_state == S_DIV) && w_div_done) begin
            r_res_avg <= w_div_q[SW-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_average <= r_res_avg;
            r_fill    <= r_res_fill;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_average    = r_average;
    assign o_fill_level = r_fill;

endmodule

>>> hdl/ima_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read.
// ----------------------------------------------------------------------------
module ima_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/ima_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ima_div
// Radix-2 restoring divider: signed dividend by unsigned non-zero divisor,
// quotient truncated toward zero. One quotient bit per cycle, then the
// sign is applied to the quotient.
// ----------------------------------------------------------------------------
module ima_div #(
    parameter int DVD_W = 40,
    parameter int DVS_W = 9
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic [DVD_W-1:0]        o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic             r_neg;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_result;

    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;
    logic [DVD_W-1:0] w_mag;

    // magnitude of the dividend
    assign w_mag = i_dividend[DVD_W-1] ? (~i_dividend + DVD_W'(1)) : i_dividend;

    // one restoring step
    assign w_shift = {r_rem, r_quo[DVD_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});
    assign w_diff  = w_shift - {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DVD_W-1];
            r_quo <= w_mag;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                r_quo <= {r_quo[DVD_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
            end else begin
                r_result <= r_neg ? (~r_quo + DVD_W'(1)) : r_quo;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_result;

endmodule
